[hw/rtl/assert_macros.svh]
// assertion macros for the upscaler rtl, used by pui_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/pui_pkg.sv]
// shared types, codes and constants of the palette upscaler
`default_nettype none

package pui_pkg;

    localparam int DEF_SRC_WIDTH    = 320;
    localparam int DEF_SRC_HEIGHT   = 200;
    localparam int DEF_MAX_SCALE    = 16;
    localparam int DEF_PALETTE_SIZE = 256;

    localparam int REQ_W      = 2;
    localparam int FB_W_W     = 13;
    localparam int FB_H_W     = 12;
    localparam int FB_S_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FB_ADDR_W  = 25;
    localparam int PIX_W      = 24;
    localparam int OFF_X_W    = 12;
    localparam int OFF_Y_W    = 11;
    localparam int Q_DEPTH    = 4;

    localparam logic [FB_W_W-1:0] RST_FB_WIDTH  = 13'd640;
    localparam logic [FB_H_W-1:0] RST_FB_HEIGHT = 12'd400;
    localparam logic [FB_S_W-1:0] RST_FB_STRIDE = 14'd640;

    typedef enum logic [REQ_W-1:0] {
        REQ_PAL    = 2'd0,
        REQ_SRC    = 2'd1,
        REQ_RENDER = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_WIDTH  = 2'd0,
        CFG_FB_HEIGHT = 2'd1,
        CFG_FB_STRIDE = 2'd2,
        CFG_PIX_FMT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_ADD,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [FB_W_W-1:0] fb_width;
        logic [FB_H_W-1:0] fb_height;
        logic [FB_S_W-1:0] fb_stride;
        logic              pixel_format;
    } t_cfg;

    typedef struct packed {
        logic [OFF_X_W-1:0] off_x;
        logic [OFF_Y_W-1:0] off_y;
    } t_geom;

    typedef struct packed {
        logic [FB_ADDR_W-1:0] base;
        logic [PIX_W-1:0]     pix;
        logic                 frame_end;
    } t_span;

endpackage

`default_nettype wire

[hw/rtl/pui_cfg.sv]
// configuration registers with derived scale and centering offsets
`default_nettype none

module pui_cfg
    import pui_pkg::*;
#(
    parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT = DEF_SRC_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg,
    output t_geom                      o_geom,
    output logic [$clog2(MAX_SCALE+1)-1:0] o_scale
);

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);
    localparam int DW_W    = $clog2(SRC_WIDTH * MAX_SCALE + 1);
    localparam int DH_W    = $clog2(SRC_HEIGHT * MAX_SCALE + 1);
    localparam int GX_W    = (DW_W > FB_W_W) ? DW_W : FB_W_W;
    localparam int GY_W    = (DH_W > FB_H_W) ? DH_W : FB_H_W;

    t_cfg               r_cfg;
    logic [SCALE_W-1:0] r_scale;
    logic [SCALE_W-1:0] n_scale;
    t_geom              r_geom;
    t_geom              n_geom;
    logic [MAX_SCALE:1] fits;
    logic [DW_W-1:0]    dst_w;
    logic [DH_W-1:0]    dst_h;
    logic [GX_W-1:0]    gx_w;
    logic [GX_W-1:0]    gx_d;
    logic [GY_W-1:0]    gy_h;
    logic [GY_W-1:0]    gy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fb_width     <= RST_FB_WIDTH;
            r_cfg.fb_height    <= RST_FB_HEIGHT;
            r_cfg.fb_stride    <= RST_FB_STRIDE;
            r_cfg.pixel_format <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FB_WIDTH:  r_cfg.fb_width     <= i_cfg_data[FB_W_W-1:0];
                CFG_FB_HEIGHT: r_cfg.fb_height    <= i_cfg_data[FB_H_W-1:0];
                CFG_FB_STRIDE: r_cfg.fb_stride    <= i_cfg_data[FB_S_W-1:0];
                CFG_PIX_FMT:   r_cfg.pixel_format <= i_cfg_data[0];
            endcase
        end
    end

    // scale is the largest k up to MAX_SCALE with both axes at least k times the source, else 1
    always_comb begin
        for (int k = 1; k <= MAX_SCALE; k++) begin
            fits[k] = (32'(r_cfg.fb_width) >= 32'(k * SRC_WIDTH))
                   && (32'(r_cfg.fb_height) >= 32'(k * SRC_HEIGHT));
        end
    end

    always_comb begin
        n_scale = SCALE_W'(1);
        for (int k = 1; k <= MAX_SCALE; k++) begin
            if (fits[k]) begin
                n_scale = SCALE_W'(k);
            end
        end
    end

    always_comb begin
        dst_w = DW_W'(SRC_WIDTH) * DW_W'(r_scale);
        dst_h = DH_W'(SRC_HEIGHT) * DH_W'(r_scale);
        gx_w  = GX_W'(r_cfg.fb_width);
        gx_d  = GX_W'(dst_w);
        gy_h  = GY_W'(r_cfg.fb_height);
        gy_d  = GY_W'(dst_h);
        n_geom.off_x = (gx_w >= gx_d) ? OFF_X_W'((gx_w - gx_d) >> 1) : '0;
        n_geom.off_y = (gy_h >= gy_d) ? OFF_Y_W'((gy_h - gy_d) >> 1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_geom  <= '0;
        end else begin
            r_scale <= n_scale;
            r_geom  <= n_geom;
        end
    end

    assign o_cfg   = r_cfg;
    assign o_geom  = r_geom;
    assign o_scale = r_scale;

endmodule

`default_nettype wire

[hw/rtl/pui_front.sv]
// front end: accepts items, holds palette and frame stores, builds span commands
`default_nettype none

module pui_front
    import pui_pkg::*;
#(
    parameter int SRC_WIDTH    = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT   = DEF_SRC_HEIGHT,
    parameter int MAX_SCALE    = DEF_MAX_SCALE,
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [7:0]            i_pal_index,
    input  wire logic [7:0]            i_red,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_blue,
    input  wire logic [15:0]           i_src_addr,
    input  wire logic [7:0]            i_src_color,
    input  wire t_cfg                  i_cfg,
    input  wire t_geom                 i_geom,
    input  wire logic [$clog2(MAX_SCALE+1)-1:0] i_scale,
    output logic                       o_push_valid,
    input  wire logic                  i_push_ready,
    output t_span                      o_span
);

    localparam int SCALE_W     = $clog2(MAX_SCALE + 1);
    localparam int REP_W       = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int ROW_W       = $clog2(SRC_HEIGHT);
    localparam int COL_W       = $clog2(SRC_WIDTH);
    localparam int FRAME_CELLS = SRC_WIDTH * SRC_HEIGHT;
    localparam int FA_W        = $clog2(FRAME_CELLS);
    localparam int PAL_W       = $clog2(PALETTE_SIZE);
    localparam int RM_W        = $clog2(SRC_HEIGHT * MAX_SCALE);
    localparam int CM_W        = $clog2(SRC_WIDTH * MAX_SCALE);
    localparam int FY_W        = $clog2(2048 + SRC_HEIGHT * MAX_SCALE + 2 * MAX_SCALE);
    localparam int XO_W        = $clog2(4096 + SRC_WIDTH * MAX_SCALE);
    localparam int PR_W        = FY_W + FB_S_W;
    localparam int VW          = (FY_W > FB_H_W) ? FY_W : FB_H_W;
    localparam int RP_W        = (REP_W + 1 > SCALE_W) ? REP_W + 1 : SCALE_W;

    t_front_state r_state;
    t_front_state n_state;

    logic [7:0]     r_frame_mem [FRAME_CELLS];
    logic [PIX_W-1:0] r_pal_mem [PALETTE_SIZE];

    logic [ROW_W-1:0] r_row;
    logic [REP_W-1:0] r_rep;
    logic [COL_W-1:0] r_col;
    logic [FA_W-1:0]  r_ptr;

    logic [7:0]       r_fq;
    logic [PIX_W-1:0] r_pal_q;
    logic             r_pal_ok;
    logic [RM_W-1:0]  r_row_mul;
    logic [CM_W-1:0]  r_col_mul;
    logic [REP_W-1:0] r_rep_s;
    logic             r_frame_end;
    logic [FY_W-1:0]  r_fy;
    logic [XO_W-1:0]  r_xoff;

    logic             w_accept;
    logic             w_pal_we;
    logic             w_src_we;
    logic             w_render;
    logic [PIX_W-1:0] w_packed;
    logic             col_last;
    logic             rep_done;
    logic             row_last;
    logic             visible;
    logic [PR_W-1:0]  prod;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_pal_we = 1'b0;
        w_src_we = 1'b0;
        w_render = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_PAL: begin
                w_pal_we = w_accept && (9'(i_pal_index) < 9'(PALETTE_SIZE));
            end
            REQ_SRC: begin
                w_src_we = w_accept && (32'(i_src_addr) < 32'(FRAME_CELLS));
            end
            REQ_RENDER: begin
                w_render = w_accept;
            end
            default: begin
            end
        endcase
    end

    assign w_packed = i_cfg.pixel_format ? {i_blue, i_green, i_red} : {i_red, i_green, i_blue};

    always_ff @(posedge i_clk) begin
        if (w_pal_we) begin
            r_pal_mem[PAL_W'(i_pal_index)] <= w_packed;
        end
        if (w_src_we) begin
            r_frame_mem[FA_W'(i_src_addr)] <= i_src_color;
        end
        if (w_render) begin
            r_fq <= r_frame_mem[r_ptr];
        end
        if (r_state == FS_MUL) begin
            r_pal_q <= r_pal_mem[PAL_W'(r_fq)];
        end
    end

    assign col_last = (r_col == COL_W'(SRC_WIDTH - 1));
    assign rep_done = (RP_W'(r_rep) + RP_W'(1)) >= RP_W'(i_scale);
    assign row_last = (r_row == ROW_W'(SRC_HEIGHT - 1));

    // raster position advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_rep <= '0;
            r_col <= '0;
            r_ptr <= '0;
        end else if (r_state == FS_MUL) begin
            if (!col_last) begin
                r_col <= r_col + COL_W'(1);
                r_ptr <= r_ptr + FA_W'(1);
            end else begin
                r_col <= '0;
                if (!rep_done) begin
                    r_rep <= r_rep + REP_W'(1);
                    r_ptr <= r_ptr - FA_W'(SRC_WIDTH - 1);
                end else begin
                    r_rep <= '0;
                    if (row_last) begin
                        r_row <= '0;
                        r_ptr <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_ptr <= r_ptr + FA_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FS_MUL) begin
            r_row_mul   <= RM_W'(r_row) * RM_W'(i_scale);
            r_col_mul   <= CM_W'(r_col) * CM_W'(i_scale);
            r_rep_s     <= r_rep;
            r_frame_end <= col_last && rep_done && row_last;
            r_pal_ok    <= 9'(r_fq) < 9'(PALETTE_SIZE);
        end
        if (r_state == FS_ADD) begin
            r_fy   <= FY_W'(i_geom.off_y) + FY_W'(r_row_mul) + FY_W'(r_rep_s);
            r_xoff <= XO_W'(i_geom.off_x) + XO_W'(r_col_mul);
        end
    end

    assign prod    = PR_W'(r_fy) * PR_W'(i_cfg.fb_stride);
    assign visible = VW'(r_fy) < VW'(i_cfg.fb_height);

    always_comb begin
        o_span.base      = FB_ADDR_W'(prod) + FB_ADDR_W'(r_xoff);
        o_span.pix       = r_pal_ok ? r_pal_q : '0;
        o_span.frame_end = r_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (w_render) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: n_state = FS_ADD;
            FS_ADD: n_state = FS_PUSH;
            FS_PUSH: begin
                if (!visible || i_push_ready) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            FS_IDLE: o_in_ready = 1'b1;
            FS_PUSH: o_push_valid = visible;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/pui_fifo.sv]
// small queue of span commands between front and back
`default_nettype none

module pui_fifo
    import pui_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_span i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_span     o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_span            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pui_back.sv]
// back end: expands span commands into pixel beats behind an output register
`default_nettype none

`include "assert_macros.svh"

module pui_back
    import pui_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [$clog2(MAX_SCALE+1)-1:0] i_scale,
    input  wire logic                  i_span_valid,
    output logic                       o_span_ready,
    input  wire t_span                 i_span,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [FB_ADDR_W-1:0]       o_fb_addr,
    output logic [PIX_W-1:0]           o_pixel_value,
    output logic                       o_span_last,
    output logic                       o_frame_done
);

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);

    logic               r_busy;
    logic [SCALE_W-1:0] r_k;
    t_span              r_span;
    logic               r_out_valid;
    logic [FB_ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]   r_pix;
    logic               r_last;
    logic               r_done;
    logic               adv;
    logic               last;
    logic               pop;

    assign adv          = r_busy && (!r_out_valid || i_out_ready);
    assign last         = (r_k == i_scale - SCALE_W'(1));
    assign o_span_ready = !r_busy || (adv && last);
    assign pop          = i_span_valid && o_span_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_k <= r_k + SCALE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_span <= i_span;
        end
        if (adv) begin
            r_addr <= r_span.base + FB_ADDR_W'(r_k);
            r_pix  <= r_span.pix;
            r_last <= last;
            r_done <= last && r_span.frame_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fb_addr     = r_addr;
    assign o_pixel_value = r_pix;
    assign o_span_last   = r_last;
    assign o_frame_done  = r_done;

    `ASSERT_IMPLIES(a_done_on_last, i_clk, i_rst_n, r_out_valid && r_done, r_last)
    `ASSERT_IMPLIES(a_k_in_span, i_clk, i_rst_n, r_busy, r_k < i_scale)
    `ASSERT_NEXT(a_busy_holds, i_clk, i_rst_n, r_busy && !(adv && last), r_busy)

endmodule

`default_nettype wire

[hw/rtl/palette_integer_upscaler_core.sv]
// top level of the palette-indexed integer upscaler
//
// input channel (i_in_valid / o_in_ready) carries palette writes, source
// pixel writes and render steps; output channel (o_out_valid / i_out_ready)
// carries one framebuffer pixel per beat with its address
// palette and source pixel writes give no beat
// a render step passes the front sequencer as frame read, palette read with
// row and column multiplies, offset sums, then stride multiply and push
// the back end then emits scale beats, one per cycle while the receiver does
// not stall, and takes the next span with the last beat of the current one
// first beat passes the multiply and sum registers, span queue and output register
// a 4-entry span queue lets the front keep accepting while the receiver
// stalls; when it fills, the front holds in its push step with o_in_ready low
// reset: 640x400 visible, stride 640, red-high packing, raster position at
// the frame origin; palette and frame contents are undefined until written
// configuration writes are registered; the user must make them while the block idles (not enforced)
`default_nettype none

module palette_integer_upscaler_core
    import pui_pkg::*;
#(
    parameter int SRC_WIDTH    = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT   = DEF_SRC_HEIGHT,
    parameter int MAX_SCALE    = DEF_MAX_SCALE,
    parameter int PALETTE_SIZE = DEF_PALETTE_SIZE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [7:0]            i_pal_index,
    input  wire logic [7:0]            i_red,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_blue,
    input  wire logic [15:0]           i_src_addr,
    input  wire logic [7:0]            i_src_color,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [FB_ADDR_W-1:0]       o_fb_addr,
    output logic [PIX_W-1:0]           o_pixel_value,
    output logic                       o_span_last,
    output logic                       o_frame_done
);

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);

    t_cfg               cfg;
    t_geom              geom;
    logic [SCALE_W-1:0] scale;
    logic               push_valid;
    logic               push_ready;
    t_span              push_data;
    logic               pop_valid;
    logic               pop_ready;
    t_span              pop_data;

    pui_cfg #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_geom     (geom),
        .o_scale    (scale)
    );

    pui_front #(
        .SRC_WIDTH    (SRC_WIDTH),
        .SRC_HEIGHT   (SRC_HEIGHT),
        .MAX_SCALE    (MAX_SCALE),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_pal_index  (i_pal_index),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_src_addr   (i_src_addr),
        .i_src_color  (i_src_color),
        .i_cfg        (cfg),
        .i_geom       (geom),
        .i_scale      (scale),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_span       (push_data)
    );

    pui_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pui_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scale       (scale),
        .i_span_valid  (pop_valid),
        .o_span_ready  (pop_ready),
        .i_span        (pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fb_addr     (o_fb_addr),
        .o_pixel_value (o_pixel_value),
        .o_span_last   (o_span_last),
        .o_frame_done  (o_frame_done)
    );

endmodule

`default_nettype wire
